>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fbpa_pkg.sv
// Types, codes and constants of the fixed block pool allocator.
// No dependencies; used by fbpa_list and fixed_block_pool_allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS  = 64;

    localparam int COUNT_W     = 7;
    localparam int BYTES_W     = 17;
    localparam int CMD_W       = 2;
    localparam int CODE_W      = 2;
    localparam int INDEX_W     = 6;
    localparam int TOTAL_W     = 23;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

    localparam logic [CODE_W-1:0] RES_OK        = 2'd0;
    localparam logic [CODE_W-1:0] RES_EMPTY     = 2'd1;
    localparam logic [CODE_W-1:0] RES_TOO_LARGE = 2'd2;
    localparam logic [CODE_W-1:0] RES_BAD_INDEX = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES      = 1'd1;

    localparam int RESET_POOL_BLOCK_COUNT = 64;
    localparam logic [BYTES_W-1:0] RESET_BLOCK_BYTES = 17'd64;

    localparam logic [BYTES_W:0] MIN_BLOCK_BYTES = 18'd4;
    localparam logic [BYTES_W:0] MAX_BLOCK_BYTES = 18'd65536;
    localparam logic [BYTES_W:0] WORD_ROUND      = 18'd3;

    typedef struct packed {
        logic pop;
        logic push;
        logic rebuild;
    } list_ctrl_t;

    function automatic logic [BYTES_W-1:0] eff_block_bytes(input logic [BYTES_W-1:0] raw);
        logic [BYTES_W:0] b;
        b = {1'b0, raw};
        if (b < MIN_BLOCK_BYTES)
        begin
            b = MIN_BLOCK_BYTES;
        end
        if (b > MAX_BLOCK_BYTES)
        begin
            b = MAX_BLOCK_BYTES;
        end
        b = (b + WORD_ROUND) & ~WORD_ROUND;
        return b[BYTES_W-1:0];
    endfunction

endpackage

>>> rtl/fixed_block_pool_allocator.sv
// An accepted item passes through an input register and then a result register.
// Throughput: one item per cycle unless the output stalls or a rebuild runs; the allocate
// chain closes through the link RAM read address, driven by the next head, with forwarding
// of a same-cycle write. Reset and every configuration write start a link RAM rebuild over the
// pool block count entries (1 to MAX_BLOCKS), while in_ready stays low. Depends on fbpa_pkg, fbpa_list.
`include "assert_macros.svh"
module fixed_block_pool_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fbpa_pkg::CMD_W-1:0]         command,
    input  logic [fbpa_pkg::BYTES_W-1:0]       request_bytes,
    input  logic [fbpa_pkg::INDEX_W-1:0]       block_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fbpa_pkg::CODE_W-1:0]        result_code,
    output logic [fbpa_pkg::INDEX_W-1:0]       granted_index,
    output logic [fbpa_pkg::COUNT_W-1:0]       free_block_count,
    output logic [fbpa_pkg::TOTAL_W-1:0]       free_bytes_total,
    output logic [fbpa_pkg::TOTAL_W-1:0]       pool_bytes,
    output logic [fbpa_pkg::BYTES_W-1:0]       largest_free_bytes
);

    localparam int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W  = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;
    localparam int PROD_W = CNT_W + fbpa_pkg::BYTES_W;
    localparam int RESET_COUNT = (MAX_BLOCKS < fbpa_pkg::RESET_POOL_BLOCK_COUNT) ?
                                 MAX_BLOCKS : fbpa_pkg::RESET_POOL_BLOCK_COUNT;
    localparam logic [CNT_W-1:0] LINK_NONE = CNT_W'(MAX_BLOCKS);

    logic [CNT_W-1:0]               eff_count_reg;
    logic [fbpa_pkg::BYTES_W-1:0]   eff_bytes_reg;
    logic [fbpa_pkg::TOTAL_W-1:0]   pool_bytes_reg;
    logic [CMP_W-1:0]               cfg_count_ext;
    logic [CNT_W-1:0]               cfg_count;
    logic [PROD_W-1:0]              pool_prod;
    logic [31:0]                    pool_prod_wide;

    logic                           item_valid_reg;
    logic [fbpa_pkg::CMD_W-1:0]     cmd_reg;
    logic [fbpa_pkg::BYTES_W-1:0]   req_reg;
    logic [fbpa_pkg::INDEX_W-1:0]   idx_reg;

    logic                           out_valid_reg;
    logic [fbpa_pkg::CODE_W-1:0]    code_reg;
    logic [fbpa_pkg::INDEX_W-1:0]   granted_reg;
    logic [fbpa_pkg::COUNT_W-1:0]   count_out_reg;
    logic [fbpa_pkg::TOTAL_W-1:0]   free_bytes_reg;
    logic [fbpa_pkg::TOTAL_W-1:0]   pool_out_reg;
    logic [fbpa_pkg::BYTES_W-1:0]   largest_reg;

    logic [CNT_W-1:0]               free_counter_reg;
    logic [CNT_W-1:0]               free_counter_next;

    logic                           advance;
    logic                           fire;
    logic                           busy;
    logic [CNT_W-1:0]               head;
    logic                           head_empty;
    fbpa_pkg::list_ctrl_t           list_ctrl;
    logic [CMP_W-1:0]               idx_ext;
    logic [CMP_W-1:0]               count_ext;
    logic [fbpa_pkg::CODE_W-1:0]    code_next;
    logic [31:0]                    granted_wide;
    logic [31:0]                    count_wide;
    logic [PROD_W-1:0]              free_prod;
    logic [31:0]                    free_prod_wide;

    // Configuration
    always_comb
    begin
        cfg_count_ext = CMP_W'(cfg_data[fbpa_pkg::COUNT_W-1:0]);
        if (cfg_count_ext == '0)
        begin
            cfg_count = CNT_W'(1);
        end
        else if (cfg_count_ext > CMP_W'(MAX_BLOCKS))
        begin
            cfg_count = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            cfg_count = cfg_count_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_count_reg <= CNT_W'(RESET_COUNT);
            eff_bytes_reg <= fbpa_pkg::RESET_BLOCK_BYTES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fbpa_pkg::CFG_POOL_BLOCK_COUNT:
                begin
                    eff_count_reg <= cfg_count;
                end
                fbpa_pkg::CFG_BLOCK_BYTES:
                begin
                    eff_bytes_reg <= fbpa_pkg::eff_block_bytes(
                                         cfg_data[fbpa_pkg::BYTES_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pool_prod      = PROD_W'(eff_count_reg) * PROD_W'(eff_bytes_reg);
    assign pool_prod_wide = 32'(pool_prod);

    always_ff @(posedge clk)
    begin
        pool_bytes_reg <= pool_prod_wide[fbpa_pkg::TOTAL_W-1:0];
    end

    // Handshake
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !busy && (!item_valid_reg || advance);
    assign fire     = item_valid_reg && advance && !busy;

    // Step
    assign head_empty = (head == LINK_NONE);
    assign idx_ext    = CMP_W'(idx_reg);
    assign count_ext  = CMP_W'(eff_count_reg);

    always_comb
    begin
        code_next         = fbpa_pkg::RES_OK;
        granted_wide      = '0;
        free_counter_next = free_counter_reg;
        list_ctrl.pop     = 1'b0;
        list_ctrl.push    = 1'b0;
        list_ctrl.rebuild = cfg_write && ((cfg_index == fbpa_pkg::CFG_POOL_BLOCK_COUNT) ||
                                          (cfg_index == fbpa_pkg::CFG_BLOCK_BYTES));
        case (cmd_reg)
            fbpa_pkg::CMD_ALLOC:
            begin
                if (req_reg > eff_bytes_reg)
                begin
                    code_next = fbpa_pkg::RES_TOO_LARGE;
                end
                else if (head_empty)
                begin
                    code_next = fbpa_pkg::RES_EMPTY;
                end
                else
                begin
                    list_ctrl.pop = fire;
                    granted_wide  = 32'(head);
                    if (free_counter_reg != '0)
                    begin
                        free_counter_next = free_counter_reg - CNT_W'(1);
                    end
                end
            end
            fbpa_pkg::CMD_FREE:
            begin
                if (idx_ext >= count_ext)
                begin
                    code_next = fbpa_pkg::RES_BAD_INDEX;
                end
                else
                begin
                    list_ctrl.push = fire;
                    if (free_counter_reg < eff_count_reg)
                    begin
                        free_counter_next = free_counter_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign count_wide     = 32'(free_counter_next);
    assign free_prod      = PROD_W'(free_counter_next) * PROD_W'(eff_bytes_reg);
    assign free_prod_wide = 32'(free_prod);

    fbpa_list #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (list_ctrl),
        .push_index (idx_ext[IDX_W-1:0]),
        .count      (eff_count_reg),
        .head       (head),
        .busy       (busy)
    );

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            free_counter_reg <= CNT_W'(RESET_COUNT);
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= fire;
            end
            if (busy)
            begin
                free_counter_reg <= eff_count_reg;
            end
            else if (fire)
            begin
                free_counter_reg <= free_counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            req_reg <= request_bytes;
            idx_reg <= block_index;
        end
        if (fire)
        begin
            code_reg       <= code_next;
            granted_reg    <= granted_wide[fbpa_pkg::INDEX_W-1:0];
            count_out_reg  <= count_wide[fbpa_pkg::COUNT_W-1:0];
            free_bytes_reg <= free_prod_wide[fbpa_pkg::TOTAL_W-1:0];
            pool_out_reg   <= pool_bytes_reg;
            largest_reg    <= eff_bytes_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign result_code        = code_reg;
    assign granted_index      = granted_reg;
    assign free_block_count   = count_out_reg;
    assign free_bytes_total   = free_bytes_reg;
    assign pool_bytes         = pool_out_reg;
    assign largest_free_bytes = largest_reg;

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, !busy,
                    free_counter_reg <= eff_count_reg, "free count above pool")
    `ASSERT_NEXT(a_pop_count, clk, rst_n, list_ctrl.pop,
                 (free_counter_reg == $past(free_counter_reg) - CNT_W'(1)) ||
                 ($past(free_counter_reg) == '0), "allocate without count drop")
    `ASSERT_IMPLIES(a_idle_in_rebuild, clk, rst_n, busy, !fire, "item stepped during rebuild")

endmodule

>>> rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fbpa_list.sv
// LIFO free list: head register, link RAM with write forwarding, rebuild sweep.
// Depends on fbpa_pkg, fbpa_ram and assert_macros.svh.
`include "assert_macros.svh"
module fbpa_list #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fbpa_pkg::list_ctrl_t             ctrl,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    push_index,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  count,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]  head,
    output logic                             busy
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] LINK_NONE = CNT_W'(MAX_BLOCKS);

    logic             sweep_reg;
    logic [IDX_W-1:0] sweep_idx_reg;
    logic [CNT_W-1:0] sweep_inc;
    logic             sweep_last;
    logic [CNT_W-1:0] sweep_link;

    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] head_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [CNT_W-1:0] rdata;
    logic             fwd_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    logic [CNT_W-1:0] head_link;

    assign sweep_inc  = CNT_W'(sweep_idx_reg) + CNT_W'(1);
    assign sweep_last = (sweep_inc >= count);
    assign sweep_link = sweep_last ? LINK_NONE : sweep_inc;

    assign head_link = fwd_reg ? fwd_data_reg : rdata;

    always_comb
    begin
        if (ctrl.rebuild || sweep_reg)
        begin
            head_next = '0;
        end
        else if (ctrl.pop)
        begin
            head_next = head_link;
        end
        else if (ctrl.push)
        begin
            head_next = CNT_W'(push_index);
        end
        else
        begin
            head_next = head_reg;
        end
    end

    always_comb
    begin
        if (sweep_reg)
        begin
            we    = 1'b1;
            waddr = sweep_idx_reg;
            wdata = sweep_link;
        end
        else
        begin
            we    = ctrl.push;
            waddr = push_index;
            wdata = head_reg;
        end
    end

    assign raddr = head_next[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            head_reg      <= '0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (ctrl.rebuild)
            begin
                sweep_reg     <= 1'b1;
                sweep_idx_reg <= '0;
            end
            else if (sweep_reg)
            begin
                if (sweep_last)
                begin
                    sweep_reg <= 1'b0;
                end
                else
                begin
                    sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
                end
            end
            head_reg <= head_next;
            fwd_reg  <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

    fbpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign head = head_reg;
    assign busy = sweep_reg;

    `ASSERT_ALWAYS(a_pop_push_excl, clk, rst_n, !(ctrl.pop && ctrl.push), "pop and push together")
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, ctrl.pop, head_reg != LINK_NONE, "pop on empty list")
    `ASSERT_IMPLIES(a_sweep_quiet, clk, rst_n, sweep_reg, !ctrl.pop && !ctrl.push, "list op during rebuild")

endmodule

>>> test/tb_top.sv
// Self-checking bench for fixed_block_pool_allocator: a directed table, then random phases
// under several pool settings; results are checked against a free-list predictor (typed
// table rows fix code, index and free count). Depends on fbpa_pkg and the allocator RTL.
module tb_top;

    localparam int unsigned POOL_SLOTS = fbpa_pkg::MAX_BLOCKS;
    localparam logic [fbpa_pkg::COUNT_W-1:0] LINK_END = 7'd64;
    localparam logic [fbpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned REQ_TOP = 131071;
    localparam int unsigned CLK_HALF = 6;
    localparam int unsigned RUN_LIMIT_CYCLES = 200000;
    localparam int unsigned LONG_HOLD_CYCLES = 80;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [fbpa_pkg::CMD_W-1:0]        cmd;
        logic [fbpa_pkg::BYTES_W-1:0]      req;
        logic [fbpa_pkg::INDEX_W-1:0]      idx;
        logic [fbpa_pkg::CFG_INDEX_W-1:0]  reg_sel;
        logic [fbpa_pkg::CFG_DATA_W-1:0]   reg_val;
        logic                              typed;
        logic [fbpa_pkg::CODE_W-1:0]       t_code;
        logic [fbpa_pkg::INDEX_W-1:0]      t_granted;
        logic [fbpa_pkg::COUNT_W-1:0]      t_free;
    } pool_request_t;

    typedef struct packed {
        logic [fbpa_pkg::CODE_W-1:0]   code;
        logic [fbpa_pkg::INDEX_W-1:0]  granted;
        logic [fbpa_pkg::COUNT_W-1:0]  free_cnt;
        logic [fbpa_pkg::TOTAL_W-1:0]  free_bytes;
        logic [fbpa_pkg::TOTAL_W-1:0]  pool_total;
        logic [fbpa_pkg::BYTES_W-1:0]  largest;
    } pool_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_write;
    logic [fbpa_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [fbpa_pkg::CMD_W-1:0]        command;
    logic [fbpa_pkg::BYTES_W-1:0]      request_bytes;
    logic [fbpa_pkg::INDEX_W-1:0]      block_index;
    logic                              out_valid;
    logic                              out_ready;
    logic [fbpa_pkg::CODE_W-1:0]       result_code;
    logic [fbpa_pkg::INDEX_W-1:0]      granted_index;
    logic [fbpa_pkg::COUNT_W-1:0]      free_block_count;
    logic [fbpa_pkg::TOTAL_W-1:0]      free_bytes_total;
    logic [fbpa_pkg::TOTAL_W-1:0]      pool_bytes;
    logic [fbpa_pkg::BYTES_W-1:0]      largest_free_bytes;

    logic [fbpa_pkg::COUNT_W-1:0]      link_of [POOL_SLOTS];
    logic [fbpa_pkg::COUNT_W-1:0]      list_head;
    logic [fbpa_pkg::COUNT_W-1:0]      free_count;
    logic [fbpa_pkg::COUNT_W-1:0]      set_count;
    logic [fbpa_pkg::BYTES_W-1:0]      set_bytes;

    pool_result_t                      owed_results [$];
    logic [fbpa_pkg::INDEX_W-1:0]      held_blocks [$];
    int unsigned                       outcome_tally [4];
    int unsigned                       items_sent = 0;
    int unsigned                       results_seen = 0;
    int unsigned                       cfg_writes = 0;
    int unsigned                       error_count = 0;
    int unsigned                       send_idle_pct = 0;
    int unsigned                       recv_stall_pct = 0;
    bit                                long_stall_req = 1'b0;

    fixed_block_pool_allocator dut (.*);

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned usable_count();
        int unsigned c;
        c = set_count;
        if (c == 0)
        begin
            c = 1;
        end
        if (c > POOL_SLOTS)
        begin
            c = POOL_SLOTS;
        end
        return c;
    endfunction

    function automatic int unsigned usable_bytes();
        int unsigned b;
        b = set_bytes;
        if (b < 4)
        begin
            b = 4;
        end
        if (b > 65536)
        begin
            b = 65536;
        end
        return (b + 3) & ~32'd3;
    endfunction

    function automatic void rebuild_free_list();
        int unsigned n;
        n = usable_count();
        for (int unsigned i = 0; i < POOL_SLOTS; i++)
        begin
            link_of[i] = (i + 1 < n) ? fbpa_pkg::COUNT_W'(i + 1) : LINK_END;
        end
        list_head = '0;
        free_count = fbpa_pkg::COUNT_W'(n);
    endfunction

    function automatic pool_result_t pool_outcome(input logic [fbpa_pkg::CMD_W-1:0] cmd,
                                                  input logic [fbpa_pkg::BYTES_W-1:0] req,
                                                  input logic [fbpa_pkg::INDEX_W-1:0] idx);
        int unsigned n;
        int unsigned eb;
        pool_result_t r;
        n = usable_count();
        eb = usable_bytes();
        r = '0;
        r.code = fbpa_pkg::RES_OK;
        if (cmd == fbpa_pkg::CMD_ALLOC)
        begin
            if (req > eb)
            begin
                r.code = fbpa_pkg::RES_TOO_LARGE;
            end
            else if (list_head >= LINK_END)
            begin
                r.code = fbpa_pkg::RES_EMPTY;
            end
            else
            begin
                r.granted = list_head[fbpa_pkg::INDEX_W-1:0];
                list_head = link_of[r.granted];
                if (free_count > 0)
                begin
                    free_count = free_count - 1'b1;
                end
            end
        end
        else if (cmd == fbpa_pkg::CMD_FREE)
        begin
            if (idx >= n)
            begin
                r.code = fbpa_pkg::RES_BAD_INDEX;
            end
            else
            begin
                link_of[idx] = list_head;
                list_head = {1'b0, idx};
                if (free_count < n)
                begin
                    free_count = free_count + 1'b1;
                end
            end
        end
        r.free_cnt = free_count;
        r.free_bytes = fbpa_pkg::TOTAL_W'(free_count * eb);
        r.pool_total = fbpa_pkg::TOTAL_W'(n * eb);
        r.largest = fbpa_pkg::BYTES_W'(eb);
        return r;
    endfunction

    function automatic pool_request_t plain_row(input logic [fbpa_pkg::CMD_W-1:0] cmd,
                                                input logic [fbpa_pkg::BYTES_W-1:0] req,
                                                input logic [fbpa_pkg::INDEX_W-1:0] idx);
        pool_request_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.cmd = cmd;
        row.req = req;
        row.idx = idx;
        return row;
    endfunction

    function automatic pool_request_t typed_row(input logic [fbpa_pkg::CMD_W-1:0] cmd,
                                                input logic [fbpa_pkg::BYTES_W-1:0] req,
                                                input logic [fbpa_pkg::INDEX_W-1:0] idx,
                                                input logic [fbpa_pkg::CODE_W-1:0] code,
                                                input logic [fbpa_pkg::INDEX_W-1:0] granted,
                                                input logic [fbpa_pkg::COUNT_W-1:0] free_cnt);
        pool_request_t row;
        row = plain_row(cmd, req, idx);
        row.typed = 1'b1;
        row.t_code = code;
        row.t_granted = granted;
        row.t_free = free_cnt;
        return row;
    endfunction

    function automatic pool_request_t cfg_row(input logic [fbpa_pkg::CFG_INDEX_W-1:0] sel,
                                              input logic [fbpa_pkg::CFG_DATA_W-1:0] val);
        pool_request_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    task automatic offer_request(input pool_request_t row, output pool_result_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= row.cmd;
        request_bytes <= row.req;
        block_index <= row.idx;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        res = pool_outcome(row.cmd, row.req, row.idx);
        if (row.typed)
        begin
            res.code = row.t_code;
            res.granted = row.t_granted;
            res.free_cnt = row.t_free;
        end
        owed_results.push_back(res);
        outcome_tally[res.code]++;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_setting(input logic [fbpa_pkg::CFG_INDEX_W-1:0] sel,
                                 input logic [fbpa_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        if (sel == fbpa_pkg::CFG_POOL_BLOCK_COUNT)
        begin
            set_count = val[fbpa_pkg::COUNT_W-1:0];
        end
        else
        begin
            set_bytes = val[fbpa_pkg::BYTES_W-1:0];
        end
        rebuild_free_list();
        cfg_writes++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input logic [fbpa_pkg::CFG_DATA_W-1:0] cnt_val,
                             input logic [fbpa_pkg::CFG_DATA_W-1:0] bytes_val,
                             input int unsigned send_pct, input int unsigned stall_pct,
                             input int unsigned n_items, input int unsigned alloc_pct,
                             input bit long_hold, input bit mid_pause);
        pool_request_t row;
        pool_result_t res;
        int unsigned pick;
        int unsigned eb;
        int unsigned k;
        int unsigned i;
        write_setting(fbpa_pkg::CFG_POOL_BLOCK_COUNT, cnt_val);
        write_setting(fbpa_pkg::CFG_BLOCK_BYTES, bytes_val);
        held_blocks.delete();
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        if (long_hold)
        begin
            long_stall_req = 1'b1;
        end
        for (i = 0; i < n_items; i++)
        begin
            if (mid_pause && i == n_items / 2)
            begin
                in_valid <= 1'b0;
                while (owed_results.size() != 0)
                begin
                    @(posedge clk);
                end
                @(negedge clk);
            end
            eb = usable_bytes();
            pick = $urandom_range(0, 99);
            row = plain_row(fbpa_pkg::CMD_STATUS, fbpa_pkg::BYTES_W'($urandom),
                            fbpa_pkg::INDEX_W'($urandom));
            if (pick < alloc_pct)
            begin
                row.cmd = fbpa_pkg::CMD_ALLOC;
                if ($urandom_range(0, 99) < 92)
                begin
                    row.req = fbpa_pkg::BYTES_W'($urandom_range(0, eb));
                end
                else
                begin
                    row.req = fbpa_pkg::BYTES_W'($urandom_range(eb + 1, REQ_TOP));
                end
            end
            else if (pick < 93)
            begin
                row.cmd = fbpa_pkg::CMD_FREE;
                if (held_blocks.size() != 0 && $urandom_range(0, 9) != 0)
                begin
                    k = $urandom_range(0, held_blocks.size() - 1);
                    row.idx = held_blocks[k];
                    held_blocks.delete(k);
                end
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                row.cmd = CMD_UNUSED;
            end
            offer_request(row, res);
            if (row.cmd == fbpa_pkg::CMD_ALLOC && res.code == fbpa_pkg::RES_OK)
            begin
                held_blocks.push_back(res.granted);
            end
        end
    endtask

    task automatic report_field(input string fname, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (owed_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual code %0d",
                         $time, result_code);
            end
            else
            begin
                want = owed_results.pop_front();
                report_field("result_code", want.code, result_code);
                report_field("granted_index", want.granted, granted_index);
                report_field("free_block_count", want.free_cnt, free_block_count);
                report_field("free_bytes_total", want.free_bytes, free_bytes_total);
                report_field("pool_bytes", want.pool_total, pool_bytes);
                report_field("largest_free_bytes", want.largest, largest_free_bytes);
            end
        end
    end

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
        $display("%0t: run limit reached with %0d results owed", $time, owed_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        pool_request_t dir_rows [$];
        pool_result_t res;
        logic [fbpa_pkg::CFG_DATA_W-1:0] rnd_cnt;
        logic [fbpa_pkg::CFG_DATA_W-1:0] rnd_bytes;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = '0;
        request_bytes = '0;
        block_index = '0;
        foreach (outcome_tally[c])
        begin
            outcome_tally[c] = 0;
        end
        set_count = fbpa_pkg::COUNT_W'(fbpa_pkg::RESET_POOL_BLOCK_COUNT);
        set_bytes = fbpa_pkg::RESET_BLOCK_BYTES;
        rebuild_free_list();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        dir_rows = '{
            typed_row(fbpa_pkg::CMD_STATUS, 0, 0, fbpa_pkg::RES_OK, 0, 64),
            typed_row(CMD_UNUSED, REQ_TOP, 63, fbpa_pkg::RES_OK, 0, 64),
            typed_row(fbpa_pkg::CMD_ALLOC, 0, 0, fbpa_pkg::RES_OK, 0, 63),
            typed_row(fbpa_pkg::CMD_ALLOC, 64, 0, fbpa_pkg::RES_OK, 1, 62),
            typed_row(fbpa_pkg::CMD_ALLOC, 65, 0, fbpa_pkg::RES_TOO_LARGE, 0, 62),
            typed_row(fbpa_pkg::CMD_ALLOC, REQ_TOP, 63, fbpa_pkg::RES_TOO_LARGE, 0, 62),
            typed_row(fbpa_pkg::CMD_FREE, 0, 63, fbpa_pkg::RES_OK, 0, 63),
            typed_row(fbpa_pkg::CMD_ALLOC, 4, 0, fbpa_pkg::RES_OK, 63, 62),
            typed_row(fbpa_pkg::CMD_FREE, 0, 0, fbpa_pkg::RES_OK, 0, 63),
            typed_row(fbpa_pkg::CMD_FREE, 0, 0, fbpa_pkg::RES_OK, 0, 64),
            typed_row(fbpa_pkg::CMD_FREE, 0, 0, fbpa_pkg::RES_OK, 0, 64),
            plain_row(fbpa_pkg::CMD_ALLOC, 1, 0),
            cfg_row(fbpa_pkg::CFG_POOL_BLOCK_COUNT, 2),
            typed_row(fbpa_pkg::CMD_ALLOC, 0, 0, fbpa_pkg::RES_OK, 0, 1),
            typed_row(fbpa_pkg::CMD_ALLOC, 0, 0, fbpa_pkg::RES_OK, 1, 0),
            typed_row(fbpa_pkg::CMD_ALLOC, 0, 0, fbpa_pkg::RES_EMPTY, 0, 0),
            typed_row(fbpa_pkg::CMD_FREE, 0, 2, fbpa_pkg::RES_BAD_INDEX, 0, 0),
            typed_row(fbpa_pkg::CMD_FREE, 0, 1, fbpa_pkg::RES_OK, 0, 1),
            cfg_row(fbpa_pkg::CFG_POOL_BLOCK_COUNT, 0),
            typed_row(fbpa_pkg::CMD_ALLOC, 0, 0, fbpa_pkg::RES_OK, 0, 0),
            typed_row(fbpa_pkg::CMD_ALLOC, 0, 0, fbpa_pkg::RES_EMPTY, 0, 0),
            cfg_row(fbpa_pkg::CFG_BLOCK_BYTES, 1),
            typed_row(fbpa_pkg::CMD_ALLOC, 4, 0, fbpa_pkg::RES_OK, 0, 0),
            typed_row(fbpa_pkg::CMD_ALLOC, 5, 0, fbpa_pkg::RES_TOO_LARGE, 0, 0),
            cfg_row(fbpa_pkg::CFG_POOL_BLOCK_COUNT, 127),
            cfg_row(fbpa_pkg::CFG_BLOCK_BYTES, REQ_TOP),
            plain_row(fbpa_pkg::CMD_STATUS, 0, 0),
            typed_row(fbpa_pkg::CMD_ALLOC, 65536, 0, fbpa_pkg::RES_OK, 0, 63),
            typed_row(fbpa_pkg::CMD_ALLOC, 65537, 0, fbpa_pkg::RES_TOO_LARGE, 0, 63),
            cfg_row(fbpa_pkg::CFG_BLOCK_BYTES, 5),
            plain_row(fbpa_pkg::CMD_ALLOC, 8, 0)
        };
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                write_setting(dir_rows[r].reg_sel, dir_rows[r].reg_val);
            end
            else
            begin
                offer_request(dir_rows[r], res);
            end
        end

        run_phase(17'd64, 17'd64, 0, 0, 250, 55, 1'b1, 1'b0);
        run_phase(17'd1, 17'd4, 85, 0, 150, 50, 1'b0, 1'b0);
        run_phase(17'd127, 17'd131071, 0, 85, 200, 65, 1'b0, 1'b0);
        run_phase(17'd8, 17'd100, 23, 23, 250, 50, 1'b0, 1'b0);
        run_phase(17'd64, 17'd65536, 0, 0, 200, 60, 1'b0, 1'b1);
        run_phase(17'd0, 17'd3, 0, 85, 150, 50, 1'b0, 1'b0);
        rnd_cnt = fbpa_pkg::CFG_DATA_W'(($urandom & 32'h1FF80) | $urandom_range(1, 64));
        rnd_bytes = fbpa_pkg::CFG_DATA_W'($urandom_range(0, REQ_TOP));
        run_phase(rnd_cnt, rnd_bytes, 23, 23, 250, 50, 1'b0, 1'b0);

        in_valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        $display("Sent %0d requests across %0d register writes; %0d results compared.",
                 items_sent, cfg_writes, results_seen);
        $display("Outcomes: %0d ok, %0d pool empty, %0d too large, %0d bad index.",
                 outcome_tally[fbpa_pkg::RES_OK], outcome_tally[fbpa_pkg::RES_EMPTY],
                 outcome_tally[fbpa_pkg::RES_TOO_LARGE], outcome_tally[fbpa_pkg::RES_BAD_INDEX]);
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_list.sv
rtl/fixed_block_pool_allocator.sv
test/tb_top.sv
